FILE: rtl/core/mstsb_pkg.sv
// Shared types and constants for the second-best spanning tree block.
package mstsb_pkg;

  localparam int NODE_W = 7;
  localparam int WIN_W  = 16;
  localparam int COST_W = 23;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WIN_W-1:0]  edge_weight;
    logic              last_edge;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0] tree_cost;
    logic [COST_W-1:0] second_cost;
    logic              second_found;
  } out_t;

  // union-find unit commands
  typedef enum logic [1:0] {
    UF_INIT,
    UF_FIND,
    UF_UNION
  } uf_op_t;

  typedef struct packed {
    logic   valid;
    uf_op_t op;
  } uf_ctl_t;

endpackage

FILE: rtl/core/mstsb_uf.sv
// Union-find unit: parent memory, set init sweep, find with path compression, union.
module mstsb_uf import mstsb_pkg::*; #(
  parameter int MAX_NODES = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  uf_ctl_t                      ctl,
  input  logic [$clog2(MAX_NODES)-1:0] node_x,
  input  logic [$clog2(MAX_NODES)-1:0] node_y,
  output logic                         done,
  output logic [$clog2(MAX_NODES)-1:0] root
);

  localparam int NW = $clog2(MAX_NODES);

  typedef enum logic [2:0] {
    U_IDLE,
    U_INIT,
    U_FRD,
    U_FCHK,
    U_CRD,
    U_CCHK
  } ustate_t;

  ustate_t       state_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] xs_r;
  logic [NW-1:0] r_r;

  logic [NW-1:0] parent_mem [MAX_NODES];
  logic [NW-1:0] rd_q;
  logic          we;
  logic [NW-1:0] wa;
  logic [NW-1:0] wd;
  logic [NW-1:0] ra;

  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = cnt_r;
    ra = (state_r == U_CRD) ? xs_r : r_r;
    unique case (state_r)
      U_IDLE: begin
        if (ctl.valid && ctl.op == UF_UNION) begin
          we = 1'b1;
          wa = node_x;
          wd = node_y;
        end
      end
      U_INIT: we = 1'b1;
      U_CCHK: begin
        if (rd_q != r_r) begin
          we = 1'b1;
          wa = xs_r;
          wd = r_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) parent_mem[wa] <= wd;
    rd_q <= parent_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      xs_r    <= '0;
      r_r     <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (ctl.valid) begin
            unique case (ctl.op)
              UF_INIT: begin
                cnt_r   <= '0;
                state_r <= U_INIT;
              end
              UF_FIND: begin
                xs_r    <= node_x;
                r_r     <= node_x;
                state_r <= U_FRD;
              end
              UF_UNION: done_r <= 1'b1;
              default:  done_r <= 1'b1;
            endcase
          end
        end
        U_INIT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == NW'(MAX_NODES - 1)) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end
        end
        U_FRD: state_r <= U_FCHK;
        U_FCHK: begin
          if (rd_q == r_r) begin
            state_r <= U_CRD;
          end else begin
            r_r     <= rd_q;
            state_r <= U_FRD;
          end
        end
        U_CRD: state_r <= U_CCHK;
        U_CCHK: begin
          if (rd_q == r_r) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end else begin
            xs_r    <= rd_q;
            state_r <= U_CRD;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = r_r;

endmodule

FILE: rtl/core/mst_and_second_best_tree.sv
// Second-best MST: edge load, in-memory insertion sort, Kruskal passes over a shared union-find.
// Load: one edge transfer per cycle while idle; the last edge makes the block busy:
//   insertion sort, then T+1 Kruskal passes (T = tree edges), each a MAX_NODES init sweep
//   plus, per edge, two finds and a union where roots differ; a rerun costing at least
//   the first adds up to node_count finds. Result waits in out register.
// Reset (rst_n low, synchronous): idle, no edges, node_count = 1, no result pending.
module mst_and_second_best_tree import mstsb_pkg::*; #(
  parameter int MAX_NODES   = 128,
  parameter int MAX_EDGES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NODE_W-1:0] cfg_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int SPW = NW + 1;                 // node scan counter, reaches MAX_NODES
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ECW = EAW + 1;                // edge counter, reaches MAX_EDGES
  localparam int KW  = WEIGHT_BITS + 2 * NODE_W;
  localparam int CW  = WEIGHT_BITS + EAW + 1;
  localparam int SW  = (CW > COST_W) ? CW : COST_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRT_CHK,
    S_SRT_RD_K,
    S_SRT_GET_K,
    S_SRT_CMP0,
    S_SRT_CMP1,
    S_SRT_PUT,
    S_RUN_START,
    S_RUN_INIT_W,
    S_E_NEXT,
    S_E_GET,
    S_E_FA,
    S_E_FB,
    S_E_UN,
    S_RUN_END,
    S_ALT_NEXT,
    S_ALT_GET,
    S_SP_START,
    S_SP_R1,
    S_SP_NEXT,
    S_SP_CHK,
    S_SP_OK,
    S_DONE
  } state_t;

  // endpoint field reduced onto the node range (restoring steps, constant divisor)
  function automatic logic [NW-1:0] node_mod(input logic [NODE_W-1:0] x);
    logic [17:0] v;
    v = 18'(x);
    for (int k = 6; k >= 0; k--) begin
      if (v >= (18'(MAX_NODES) << k)) v = v - (18'(MAX_NODES) << k);
    end
    return NW'(v);
  endfunction

  function automatic logic [COST_W-1:0] sat(input logic [CW-1:0] c);
    logic [SW-1:0] ce;
    ce = SW'(c);
    return (ce > SW'(COST_MAX)) ? COST_MAX : ce[COST_W-1:0];
  endfunction

  state_t             state_r;
  logic [NODE_W-1:0]  node_count_r;
  logic [ECW-1:0]     total_r;
  logic [ECW-1:0]     i_r;
  logic [ECW-1:0]     j_r;
  logic [ECW-1:0]     e_r;
  logic [KW-1:0]      key_r;
  logic [KW-1:0]      edge_r;
  logic [EAW-1:0]     skip_r;
  logic               first_pass_r;
  logic [CW-1:0]      cost_r;
  logic [CW-1:0]      first_cost_r;
  logic [CW-1:0]      best_r;
  logic               found_r;
  logic [SPW-1:0]     cnt_r;
  logic [SPW-1:0]     t_r;
  logic [SPW-1:0]     k_r;
  logic [NW-1:0]      ra_r;
  logic [NW-1:0]      root1_r;
  uf_ctl_t            uf_ctl_r;
  logic [NW-1:0]      uf_x_r;
  logic [NW-1:0]      uf_y_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               uf_done;
  logic [NW-1:0]      uf_root;
  logic [SPW-1:0]     nc;

  // edge store
  logic [KW-1:0]      edge_mem [MAX_EDGES];
  logic [KW-1:0]      er_q;
  logic               er_we;
  logic [EAW-1:0]     er_wa;
  logic [KW-1:0]      er_wd;
  logic [EAW-1:0]     er_ra;

  // tree edge positions
  logic [EAW-1:0]     tl_mem [MAX_NODES];
  logic [EAW-1:0]     tl_q;
  logic               tl_we;

  logic               in_fire;
  logic [KW-1:0]      new_key;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign new_key   = {WEIGHT_BITS'(in_data.edge_weight), in_data.node_a, in_data.node_b};
  assign nc = (int'(node_count_r) >= MAX_NODES) ? SPW'(MAX_NODES - 1) : SPW'(node_count_r);

  always_comb begin
    er_we = 1'b0;
    er_wa = j_r[EAW-1:0];
    er_wd = key_r;
    er_ra = e_r[EAW-1:0];
    unique case (state_r)
      S_IDLE: begin
        er_we = in_fire && (total_r < ECW'(MAX_EDGES));
        er_wa = total_r[EAW-1:0];
        er_wd = new_key;
      end
      S_SRT_RD_K: er_ra = i_r[EAW-1:0];
      S_SRT_CMP0: er_ra = EAW'(j_r - 1'b1);
      S_SRT_CMP1: begin
        er_we = (er_q > key_r);
        er_wd = er_q;
      end
      S_SRT_PUT: er_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (er_we) edge_mem[er_wa] <= er_wd;
    er_q <= edge_mem[er_ra];
  end

  // record tree edge on a successful union in the first pass
  assign tl_we = (state_r == S_E_FB) && uf_done && (uf_root != ra_r) && first_pass_r &&
                 (cnt_r < SPW'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (tl_we) tl_mem[cnt_r[NW-1:0]] <= e_r[EAW-1:0];
    tl_q <= tl_mem[t_r[NW-1:0]];
  end

  mstsb_uf #(
    .MAX_NODES(MAX_NODES)
  ) u_uf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (uf_ctl_r),
    .node_x (uf_x_r),
    .node_y (uf_y_r),
    .done   (uf_done),
    .root   (uf_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_W'(1);
      total_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      e_r          <= '0;
      key_r        <= '0;
      edge_r       <= '0;
      skip_r       <= '0;
      first_pass_r <= 1'b1;
      cost_r       <= '0;
      first_cost_r <= '0;
      best_r       <= '1;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      t_r          <= '0;
      k_r          <= '0;
      ra_r         <= '0;
      root1_r      <= '0;
      uf_ctl_r     <= '{valid: 1'b0, op: UF_INIT};
      uf_x_r       <= '0;
      uf_y_r       <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      uf_ctl_r.valid <= 1'b0;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (total_r < ECW'(MAX_EDGES)) total_r <= total_r + 1'b1;
            if (in_data.last_edge) begin
              i_r     <= ECW'(1);
              state_r <= S_SRT_CHK;
            end
          end
        end

        // insertion sort on the edge store
        S_SRT_CHK: begin
          if (i_r >= total_r) begin
            first_pass_r <= 1'b1;
            found_r      <= 1'b0;
            best_r       <= '1;
            cnt_r        <= '0;
            state_r      <= S_RUN_START;
          end else begin
            state_r <= S_SRT_RD_K;
          end
        end
        S_SRT_RD_K: state_r <= S_SRT_GET_K;
        S_SRT_GET_K: begin
          key_r   <= er_q;
          j_r     <= i_r;
          state_r <= S_SRT_CMP0;
        end
        S_SRT_CMP0: state_r <= (j_r == '0) ? S_SRT_PUT : S_SRT_CMP1;
        S_SRT_CMP1: begin
          if (er_q > key_r) begin
            j_r     <= j_r - 1'b1;
            state_r <= S_SRT_CMP0;
          end else begin
            state_r <= S_SRT_PUT;
          end
        end
        S_SRT_PUT: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_SRT_CHK;
        end

        // one Kruskal pass
        S_RUN_START: begin
          uf_ctl_r <= '{valid: 1'b1, op: UF_INIT};
          cost_r   <= '0;
          e_r      <= '0;
          state_r  <= S_RUN_INIT_W;
        end
        S_RUN_INIT_W: if (uf_done) state_r <= S_E_NEXT;
        S_E_NEXT: begin
          if (e_r >= total_r) begin
            state_r <= S_RUN_END;
          end else if (!first_pass_r && e_r[EAW-1:0] == skip_r) begin
            e_r <= e_r + 1'b1;
          end else begin
            state_r <= S_E_GET;
          end
        end
        S_E_GET: begin
          edge_r   <= er_q;
          uf_ctl_r <= '{valid: 1'b1, op: UF_FIND};
          uf_x_r   <= node_mod(er_q[2*NODE_W-1:NODE_W]);
          state_r  <= S_E_FA;
        end
        S_E_FA: begin
          if (uf_done) begin
            ra_r     <= uf_root;
            uf_ctl_r <= '{valid: 1'b1, op: UF_FIND};
            uf_x_r   <= node_mod(edge_r[NODE_W-1:0]);
            state_r  <= S_E_FB;
          end
        end
        S_E_FB: begin
          if (uf_done) begin
            if (uf_root != ra_r) begin
              uf_ctl_r <= '{valid: 1'b1, op: UF_UNION};
              uf_x_r   <= ra_r;
              uf_y_r   <= uf_root;
              cost_r   <= cost_r + CW'(edge_r[KW-1:2*NODE_W]);
              if (tl_we) cnt_r <= cnt_r + 1'b1;
              state_r  <= S_E_UN;
            end else begin
              e_r     <= e_r + 1'b1;
              state_r <= S_E_NEXT;
            end
          end
        end
        S_E_UN: begin
          if (uf_done) begin
            e_r     <= e_r + 1'b1;
            state_r <= S_E_NEXT;
          end
        end
        S_RUN_END: begin
          if (first_pass_r) begin
            first_cost_r <= cost_r;
            first_pass_r <= 1'b0;
            t_r          <= '0;
            state_r      <= S_ALT_NEXT;
          end else if (cost_r >= first_cost_r) begin
            state_r <= S_SP_START;
          end else begin
            t_r     <= t_r + 1'b1;
            state_r <= S_ALT_NEXT;
          end
        end

        // next tree edge to leave out
        S_ALT_NEXT: state_r <= (t_r >= cnt_r) ? S_DONE : S_ALT_GET;
        S_ALT_GET: begin
          skip_r  <= tl_q;
          state_r <= S_RUN_START;
        end

        // spanning check over nodes 1..nc
        S_SP_START: begin
          if (nc == '0) begin
            state_r <= S_SP_OK;
          end else begin
            uf_ctl_r <= '{valid: 1'b1, op: UF_FIND};
            uf_x_r   <= NW'(1);
            state_r  <= S_SP_R1;
          end
        end
        S_SP_R1: begin
          if (uf_done) begin
            root1_r <= uf_root;
            k_r     <= SPW'(2);
            state_r <= S_SP_NEXT;
          end
        end
        S_SP_NEXT: begin
          if (k_r > nc) begin
            state_r <= S_SP_OK;
          end else begin
            uf_ctl_r <= '{valid: 1'b1, op: UF_FIND};
            uf_x_r   <= k_r[NW-1:0];
            state_r  <= S_SP_CHK;
          end
        end
        S_SP_CHK: begin
          if (uf_done) begin
            if (uf_root != root1_r) begin
              t_r     <= t_r + 1'b1;
              state_r <= S_ALT_NEXT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_SP_NEXT;
            end
          end
        end
        S_SP_OK: begin
          if (!found_r || cost_r < best_r) best_r <= cost_r;
          found_r <= 1'b1;
          t_r     <= t_r + 1'b1;
          state_r <= S_ALT_NEXT;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.tree_cost    <= sat(first_cost_r);
            out_data_r.second_cost  <= found_r ? sat(best_r) : '0;
            out_data_r.second_found <= found_r;
            total_r                 <= '0;
            state_r                 <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
